@@ rtl/core/gaps_pkg.sv @@
package gaps_pkg;

  localparam int GRID_COLS_DEF = 32;
  localparam int GRID_ROWS_DEF = 32;

  localparam int LEN_W = 10;
  localparam int PATH_DEPTH = 1023;
  localparam logic [LEN_W-1:0] PATH_CAP = 10'd1023;
  localparam int XY_W = 5;

  localparam int COST_STRAIGHT = 10;
  localparam int COST_DIAG = 14;

  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_READ   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_UNSEEN = 2'd0,
    ST_OPEN   = 2'd1,
    ST_CLOSED = 2'd2,
    ST_SPARE  = 2'd3
  } cell_st_t;

  typedef struct packed {
    logic walk_we;
    logic walk_open;
    logic go;
  } srch_cmd_t;

  typedef struct packed {
    logic             ready;
    logic             done;
    logic             found;
    logic [LEN_W-1:0] len;
    logic             path_we;
    logic [LEN_W-1:0] path_idx;
  } srch_stat_t;

  // Step of direction k as {negative, positive}; order UL, UR, DR, DL, U, R, D, L.
  function automatic logic [1:0] step_dx(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd0: r = 2'b10;
      3'd1: r = 2'b01;
      3'd2: r = 2'b01;
      3'd3: r = 2'b10;
      3'd4: r = 2'b00;
      3'd5: r = 2'b01;
      3'd6: r = 2'b00;
      3'd7: r = 2'b10;
      default: r = 2'b00;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] step_dy(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd0: r = 2'b10;
      3'd1: r = 2'b10;
      3'd2: r = 2'b01;
      3'd3: r = 2'b01;
      3'd4: r = 2'b10;
      3'd5: r = 2'b00;
      3'd6: r = 2'b01;
      3'd7: r = 2'b00;
      default: r = 2'b00;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/gaps_search.sv @@
module gaps_search import gaps_pkg::*; #(
  parameter int GRID_COLS = GRID_COLS_DEF,
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  localparam int CW = $clog2(GRID_COLS),
  localparam int RW = $clog2(GRID_ROWS),
  localparam int AW = CW + RW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  srch_cmd_t     cmd,
  input  logic [CW-1:0] cmd_x,
  input  logic [RW-1:0] cmd_y,
  input  logic [CW-1:0] goal_x,
  input  logic [RW-1:0] goal_y,
  output srch_stat_t    stat,
  output logic [AW-1:0] path_cell
);

  localparam int NC = 1 << AW;
  localparam int GW = $clog2(COST_DIAG * GRID_COLS * GRID_ROWS + 1);
  localparam int FW = $clog2(COST_DIAG * GRID_COLS * GRID_ROWS + GRID_COLS + GRID_ROWS + 1);

  typedef struct packed {
    cell_st_t      st;
    logic [3:0]    par;
    logic [AW-1:0] ord;
    logic [GW-1:0] g;
    logic [FW-1:0] f;
  } node_t;

  typedef enum logic [11:0] {
    S_CLEAR    = 12'b000000000001,
    S_IDLE     = 12'b000000000010,
    S_INIT     = 12'b000000000100,
    S_SCAN     = 12'b000000001000,
    S_SCAN_END = 12'b000000010000,
    S_PICK     = 12'b000000100000,
    S_WALK     = 12'b000001000000,
    S_WALK_END = 12'b000010000000,
    S_NREAD    = 12'b000100000000,
    S_NUPD     = 12'b001000000000,
    S_TRACE_RD = 12'b010000000000,
    S_TRACE_WR = 12'b100000000000
  } state_t;

  function automatic logic [FW-1:0] heur(input logic [CW-1:0] ax, input logic [RW-1:0] ay,
                                         input logic [CW-1:0] bx, input logic [RW-1:0] by);
    logic [CW-1:0] dx;
    logic [RW-1:0] dy;
    dx = (ax >= bx) ? ax - bx : bx - ax;
    dy = (ay >= by) ? ay - by : by - ay;
    return FW'(dx) + FW'(dy);
  endfunction

  node_t         node_mem [NC];
  logic          walk_mem [NC];
  node_t         node_q;
  logic          walk_q;

  logic          node_we;
  logic [AW-1:0] node_wa, node_ra;
  node_t         node_wd;
  logic          walk_we;
  logic [AW-1:0] walk_wa, walk_ra;
  logic          walk_wd;
  logic          path_we;

  state_t        state_r, state_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] sx_r, sx_nxt, gx_r, gx_nxt;
  logic [RW-1:0] sy_r, sy_nxt, gy_r, gy_nxt;
  logic          scan_vld_r, scan_vld_nxt;
  logic [AW-1:0] scan_tag_r, scan_tag_nxt;
  logic          best_vld_r, best_vld_nxt;
  logic [AW-1:0] best_a_r, best_a_nxt;
  logic [FW-1:0] best_f_r, best_f_nxt;
  logic [AW-1:0] best_o_r, best_o_nxt;
  logic [GW-1:0] best_g_r, best_g_nxt;
  logic [3:0]    best_p_r, best_p_nxt;
  logic [2:0]    k_r, k_nxt;
  logic [7:0]    wbits_r, wbits_nxt;
  logic          wk_vld_r, wk_vld_nxt;
  logic [2:0]    wk_k_r, wk_k_nxt;
  logic          wk_in_r, wk_in_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [LEN_W-1:0] plen_r, plen_nxt;
  logic          found_r, found_nxt;
  logic          done_r, done_nxt;

  // neighbor k_r of the expanded cell
  logic [CW-1:0] bx, nx;
  logic [RW-1:0] by, ny;
  logic [1:0]    sdx, sdy;
  logic          n_in, n_ok;
  logic [AW-1:0] n_addr, start_a, goal_a;
  logic [GW-1:0] t_cost;
  logic [FW-1:0] f_new;
  // parent step walked back during trace
  logic [2:0]    pk;
  logic [1:0]    pdx, pdy;
  logic [CW-1:0] px;
  logic [RW-1:0] py;

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_wa] <= node_wd;
    node_q <= node_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (walk_we) walk_mem[walk_wa] <= walk_wd;
    walk_q <= walk_mem[walk_ra];
  end

  assign start_a = {sy_r, sx_r};
  assign goal_a  = {gy_r, gx_r};
  assign bx  = best_a_r[CW-1:0];
  assign by  = best_a_r[AW-1:CW];
  assign sdx = step_dx(k_r);
  assign sdy = step_dy(k_r);
  assign nx  = sdx[1] ? bx - 1'b1 : (sdx[0] ? bx + 1'b1 : bx);
  assign ny  = sdy[1] ? by - 1'b1 : (sdy[0] ? by + 1'b1 : by);
  assign n_in = !(sdx[1] && bx == '0) && !(sdx[0] && int'(bx) == GRID_COLS - 1) &&
                !(sdy[1] && by == '0) && !(sdy[0] && int'(by) == GRID_ROWS - 1);
  assign n_addr = {ny, nx};
  assign t_cost = best_g_r + (k_r[2] ? GW'(COST_STRAIGHT) : GW'(COST_DIAG));
  assign f_new  = FW'(t_cost) + heur(nx, ny, gx_r, gy_r);

  // diagonals need both orthogonal cells they cut past
  always_comb begin
    case (k_r)
      3'd0: n_ok = wbits_r[0] && wbits_r[7] && wbits_r[4];
      3'd1: n_ok = wbits_r[1] && wbits_r[5] && wbits_r[4];
      3'd2: n_ok = wbits_r[2] && wbits_r[5] && wbits_r[6];
      3'd3: n_ok = wbits_r[3] && wbits_r[7] && wbits_r[6];
      default: n_ok = wbits_r[k_r];
    endcase
  end

  assign pk  = 3'(node_q.par - 4'd1);
  assign pdx = step_dx(pk);
  assign pdy = step_dy(pk);
  assign px  = pdx[1] ? cur_r[CW-1:0] + 1'b1 :
               (pdx[0] ? cur_r[CW-1:0] - 1'b1 : cur_r[CW-1:0]);
  assign py  = pdy[1] ? cur_r[AW-1:CW] + 1'b1 :
               (pdy[0] ? cur_r[AW-1:CW] - 1'b1 : cur_r[AW-1:CW]);

  always_comb begin
    state_nxt    = state_r;
    ptr_nxt      = ptr_r;
    sx_nxt       = sx_r;
    sy_nxt       = sy_r;
    gx_nxt       = gx_r;
    gy_nxt       = gy_r;
    scan_vld_nxt = 1'b0;
    scan_tag_nxt = scan_tag_r;
    best_vld_nxt = best_vld_r;
    best_a_nxt   = best_a_r;
    best_f_nxt   = best_f_r;
    best_o_nxt   = best_o_r;
    best_g_nxt   = best_g_r;
    best_p_nxt   = best_p_r;
    k_nxt        = k_r;
    wbits_nxt    = wbits_r;
    wk_vld_nxt   = 1'b0;
    wk_k_nxt     = wk_k_r;
    wk_in_nxt    = wk_in_r;
    cnt_nxt      = cnt_r;
    cur_nxt      = cur_r;
    plen_nxt     = plen_r;
    found_nxt    = found_r;
    done_nxt     = 1'b0;
    node_we      = 1'b0;
    node_wa      = ptr_r;
    node_wd      = '0;
    node_ra      = ptr_r;
    walk_we      = 1'b0;
    walk_wa      = ptr_r;
    walk_wd      = 1'b0;
    walk_ra      = n_addr;
    path_we      = 1'b0;

    // track the lowest f, earliest opened, among scanned open cells
    if (scan_vld_r && node_q.st == ST_OPEN &&
        (!best_vld_r || node_q.f < best_f_r ||
         (node_q.f == best_f_r && node_q.ord < best_o_r))) begin
      best_vld_nxt = 1'b1;
      best_a_nxt   = scan_tag_r;
      best_f_nxt   = node_q.f;
      best_o_nxt   = node_q.ord;
      best_g_nxt   = node_q.g;
      best_p_nxt   = node_q.par;
    end

    if (wk_vld_r) wbits_nxt[wk_k_r] = wk_in_r && !walk_q;

    case (state_r)
      S_CLEAR: begin
        walk_we = 1'b1;
        walk_wd = 1'b0;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == {AW{1'b1}}) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cmd.walk_we) begin
          walk_we = 1'b1;
          walk_wa = {cmd_y, cmd_x};
          walk_wd = !cmd.walk_open;
        end
        if (cmd.go) begin
          sx_nxt    = cmd_x;
          sy_nxt    = cmd_y;
          gx_nxt    = goal_x;
          gy_nxt    = goal_y;
          ptr_nxt   = '0;
          found_nxt = 1'b0;
          plen_nxt  = '0;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        node_we = 1'b1;
        if (ptr_r == start_a) begin
          node_wd.st = ST_OPEN;
          node_wd.f  = heur(sx_r, sy_r, gx_r, gy_r);
        end
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == {AW{1'b1}}) begin
          cnt_nxt      = AW'(1);
          best_vld_nxt = 1'b0;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        scan_vld_nxt = 1'b1;
        scan_tag_nxt = ptr_r;
        ptr_nxt      = ptr_r + 1'b1;
        if (ptr_r == {AW{1'b1}}) state_nxt = S_SCAN_END;
      end
      S_SCAN_END: state_nxt = S_PICK;
      S_PICK: begin
        if (!best_vld_r) begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else if (best_a_r == goal_a) begin
          found_nxt = 1'b1;
          cur_nxt   = goal_a;
          state_nxt = S_TRACE_RD;
        end else begin
          node_we   = 1'b1;
          node_wa   = best_a_r;
          node_wd   = '{st: ST_CLOSED, par: best_p_r, ord: best_o_r, g: best_g_r, f: best_f_r};
          k_nxt     = '0;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        wk_vld_nxt = 1'b1;
        wk_k_nxt   = k_r;
        wk_in_nxt  = n_in;
        k_nxt      = k_r + 3'd1;
        if (k_r == 3'd7) state_nxt = S_WALK_END;
      end
      S_WALK_END: state_nxt = S_NREAD;
      S_NREAD: begin
        node_ra = n_addr;
        if (n_ok) begin
          state_nxt = S_NUPD;
        end else if (k_r == 3'd7) begin
          ptr_nxt      = '0;
          best_vld_nxt = 1'b0;
          state_nxt    = S_SCAN;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      S_NUPD: begin
        node_wa = n_addr;
        node_wd = '{st: ST_OPEN, par: {1'b0, k_r} + 4'd1, ord: node_q.ord, g: t_cost, f: f_new};
        if (node_q.st == ST_UNSEEN) begin
          node_we     = 1'b1;
          node_wd.ord = cnt_r;
          cnt_nxt     = cnt_r + 1'b1;
        end else if (node_q.st == ST_OPEN && t_cost < node_q.g) begin
          node_we = 1'b1;
        end
        if (k_r == 3'd7) begin
          ptr_nxt      = '0;
          best_vld_nxt = 1'b0;
          state_nxt    = S_SCAN;
        end else begin
          k_nxt     = k_r + 3'd1;
          state_nxt = S_NREAD;
        end
      end
      S_TRACE_RD: begin
        node_ra   = cur_r;
        state_nxt = S_TRACE_WR;
      end
      S_TRACE_WR: begin
        if (node_q.par == 4'd0 || cur_r == start_a) begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          if (plen_r < PATH_CAP) begin
            path_we  = 1'b1;
            plen_nxt = plen_r + 10'd1;
          end
          cur_nxt   = {py, px};
          state_nxt = S_TRACE_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      ptr_r      <= '0;
      scan_vld_r <= 1'b0;
      wk_vld_r   <= 1'b0;
      best_vld_r <= 1'b0;
      found_r    <= 1'b0;
      plen_r     <= '0;
      done_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ptr_r      <= ptr_nxt;
      scan_vld_r <= scan_vld_nxt;
      wk_vld_r   <= wk_vld_nxt;
      best_vld_r <= best_vld_nxt;
      found_r    <= found_nxt;
      plen_r     <= plen_nxt;
      done_r     <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    gx_r       <= gx_nxt;
    gy_r       <= gy_nxt;
    scan_tag_r <= scan_tag_nxt;
    best_a_r   <= best_a_nxt;
    best_f_r   <= best_f_nxt;
    best_o_r   <= best_o_nxt;
    best_g_r   <= best_g_nxt;
    best_p_r   <= best_p_nxt;
    k_r        <= k_nxt;
    wbits_r    <= wbits_nxt;
    wk_k_r     <= wk_k_nxt;
    wk_in_r    <= wk_in_nxt;
    cnt_r      <= cnt_nxt;
    cur_r      <= cur_nxt;
  end

  assign stat.ready    = (state_r == S_IDLE);
  assign stat.done     = done_r;
  assign stat.found    = found_r;
  assign stat.len      = plen_r;
  assign stat.path_we  = path_we;
  assign stat.path_idx = plen_r;
  assign path_cell     = cur_r;

endmodule

@@ rtl/core/grid_astar_path_search.sv @@
// Cell write, mode three, path read and search each return one result. A search scans
// every cell of the padded grid (1024 at 32x32) for the open cell to expand, then traces
// the path back from the goal; the open-cell scan dominates. One at a time.
// Reset is synchronous; afterwards a pass over every cell marks each one walkable,
// with input stalled until it ends.
module grid_astar_path_search import gaps_pkg::*; #(
  parameter int GRID_COLS = GRID_COLS_DEF,
  parameter int GRID_ROWS = GRID_ROWS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_mode,
  input  logic [XY_W-1:0]  in_cell_x,
  input  logic [XY_W-1:0]  in_cell_y,
  input  logic             in_walkable,
  input  logic [XY_W-1:0]  in_goal_x,
  input  logic [XY_W-1:0]  in_goal_y,
  input  logic [LEN_W-1:0] in_path_index,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_found,
  output logic [LEN_W-1:0] out_path_length,
  output logic [XY_W-1:0]  out_path_x,
  output logic [XY_W-1:0]  out_path_y,
  output logic             out_index_ok
);

  localparam int CW = $clog2(GRID_COLS);
  localparam int RW = $clog2(GRID_ROWS);
  localparam int AW = CW + RW;

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_SRCH = 4'b0010,
    T_READ = 4'b0100,
    T_HOLD = 4'b1000
  } top_st_t;

  top_st_t          state_r, state_nxt;
  logic             found_r, found_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [XY_W-1:0]  res_x_r, res_x_nxt, res_y_r, res_y_nxt;
  logic             res_ok_r, res_ok_nxt;
  logic             ov_r, ov_nxt;
  logic             of_r;
  logic [LEN_W-1:0] ol_r;
  logic [XY_W-1:0]  ox_r, oy_r;
  logic             ook_r;

  srch_cmd_t        cmd;
  srch_stat_t       stat;
  logic [AW-1:0]    path_cell;
  logic [AW-1:0]    path_mem [PATH_DEPTH];
  logic [AW-1:0]    path_q;

  logic             accept, load, cell_in, goal_in;
  mode_t            mode;

  gaps_search #(
    .GRID_COLS(GRID_COLS),
    .GRID_ROWS(GRID_ROWS)
  ) u_search (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cmd_x    (CW'(in_cell_x)),
    .cmd_y    (RW'(in_cell_y)),
    .goal_x   (CW'(in_goal_x)),
    .goal_y   (RW'(in_goal_y)),
    .stat     (stat),
    .path_cell(path_cell)
  );

  always_ff @(posedge clk) begin
    if (stat.path_we) path_mem[stat.path_idx] <= path_cell;
    path_q <= path_mem[in_path_index];
  end

  assign in_stall = (state_r != T_IDLE) || !stat.ready;
  assign accept   = in_valid && !in_stall;
  assign mode     = mode_t'(in_mode);
  assign cell_in  = int'(in_cell_x) < GRID_COLS && int'(in_cell_y) < GRID_ROWS;
  assign goal_in  = int'(in_goal_x) < GRID_COLS && int'(in_goal_y) < GRID_ROWS;
  assign load     = (state_r == T_HOLD) && (!ov_r || !out_stall);

  assign cmd.walk_we   = accept && mode == MODE_WRITE && cell_in;
  assign cmd.walk_open = in_walkable;
  assign cmd.go        = accept && mode == MODE_SEARCH && cell_in && goal_in;

  always_comb begin
    state_nxt  = state_r;
    found_nxt  = found_r;
    len_nxt    = len_r;
    res_x_nxt  = res_x_r;
    res_y_nxt  = res_y_r;
    res_ok_nxt = res_ok_r;
    case (state_r)
      T_IDLE: begin
        if (accept) begin
          res_x_nxt  = '0;
          res_y_nxt  = '0;
          res_ok_nxt = 1'b0;
          state_nxt  = T_HOLD;
          case (mode)
            MODE_SEARCH: begin
              found_nxt = 1'b0;
              len_nxt   = '0;
              if (cell_in && goal_in) state_nxt = T_SRCH;
            end
            MODE_READ: begin
              if (in_path_index < len_r) state_nxt = T_READ;
            end
            default: state_nxt = T_HOLD;
          endcase
        end
      end
      T_SRCH: begin
        if (stat.done) begin
          found_nxt = stat.found;
          len_nxt   = stat.len;
          state_nxt = T_HOLD;
        end
      end
      T_READ: begin
        res_x_nxt  = XY_W'(path_q[CW-1:0]);
        res_y_nxt  = XY_W'(path_q[AW-1:CW]);
        res_ok_nxt = 1'b1;
        state_nxt  = T_HOLD;
      end
      T_HOLD: begin
        if (load) state_nxt = T_IDLE;
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  assign ov_nxt = (ov_r && out_stall) || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      found_r <= 1'b0;
      len_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      found_r <= found_nxt;
      len_r   <= len_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_x_r  <= res_x_nxt;
    res_y_r  <= res_y_nxt;
    res_ok_r <= res_ok_nxt;
    if (load) begin
      of_r  <= found_r;
      ol_r  <= len_r;
      ox_r  <= res_x_r;
      oy_r  <= res_y_r;
      ook_r <= res_ok_r;
    end
  end

  assign out_valid       = ov_r;
  assign out_found       = of_r;
  assign out_path_length = ol_r;
  assign out_path_x      = ox_r;
  assign out_path_y      = oy_r;
  assign out_index_ok    = ook_r;

endmodule

@@ verif/path_search_checker.sv @@
`timescale 1ns / 100ps

module path_search_checker import gaps_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [1:0]       in_mode,
  input  logic [XY_W-1:0]  in_cell_x,
  input  logic [XY_W-1:0]  in_cell_y,
  input  logic             in_walkable,
  input  logic [XY_W-1:0]  in_goal_x,
  input  logic [XY_W-1:0]  in_goal_y,
  input  logic [LEN_W-1:0] in_path_index,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic             out_found,
  input  logic [LEN_W-1:0] out_path_length,
  input  logic [XY_W-1:0]  out_path_x,
  input  logic [XY_W-1:0]  out_path_y,
  input  logic             out_index_ok,
  output int               fail_count,
  output int               outstanding
);

  localparam int COLS = 32;
  localparam int ROWS = 32;
  localparam int CELLS = COLS * ROWS;

  typedef struct packed {
    logic             found;
    logic [LEN_W-1:0] length;
    logic [XY_W-1:0]  px;
    logic [XY_W-1:0]  py;
    logic             ok;
  } path_reply_t;

  // Direction order: up-left, up-right, down-right, down-left, up, right, down, left
  int dir_dx[8] = '{-1, 1, 1, -1, 0, 1, 0, -1};
  int dir_dy[8] = '{-1, -1, 1, 1, -1, 0, 1, 0};

  bit       walk_bits[CELLS];
  int       g_cost[CELLS];
  int       f_est[CELLS];
  int       open_seq[CELLS];
  cell_st_t status[CELLS];
  int       par_dir[CELLS];
  int       route[PATH_DEPTH];
  int       route_len;
  bit       goal_reached;
  path_reply_t reply_q[$];

  initial begin
    foreach (walk_bits[i]) walk_bits[i] = 1'b1;
    route_len = 0;
    goal_reached = 1'b0;
    fail_count = 0;
    outstanding = 0;
  end

  function automatic int dist_h(int x, int y, int gx, int gy);
    return (x > gx ? x - gx : gx - x) + (y > gy ? y - gy : gy - y);
  endfunction

  function automatic void search_route(int sx, int sy, int gx, int gy);
    int start, goal, seq, best, cx, cy, nx, ny, n, t, c, d;
    bit better;
    goal_reached = 1'b0;
    route_len = 0;
    foreach (status[i]) begin
      status[i] = ST_UNSEEN;
      par_dir[i] = 0;
      g_cost[i] = 0;
      f_est[i] = 0;
      open_seq[i] = 0;
    end
    start = sy * COLS + sx;
    goal = gy * COLS + gx;
    seq = 0;
    status[start] = ST_OPEN;
    f_est[start] = dist_h(sx, sy, gx, gy);
    open_seq[start] = seq++;
    forever begin
      best = -1;
      for (int i = 0; i < CELLS; i++) begin
        if (status[i] != ST_OPEN) continue;
        if (best < 0 || f_est[i] < f_est[best] ||
            (f_est[i] == f_est[best] && open_seq[i] < open_seq[best]))
          best = i;
      end
      if (best < 0) return;
      if (best == goal) break;
      status[best] = ST_CLOSED;
      cx = best % COLS;
      cy = best / COLS;
      for (int k = 0; k < 8; k++) begin
        nx = cx + dir_dx[k];
        ny = cy + dir_dy[k];
        if (nx < 0 || ny < 0 || nx >= COLS || ny >= ROWS) continue;
        n = ny * COLS + nx;
        if (!walk_bits[n]) continue;
        // no corner cutting past a blocked orthogonal cell
        if (k < 4 && (!walk_bits[cy * COLS + nx] || !walk_bits[ny * COLS + cx])) continue;
        if (status[n] == ST_CLOSED) continue;
        t = g_cost[best] + (k < 4 ? COST_DIAG : COST_STRAIGHT);
        if (status[n] != ST_OPEN) begin
          status[n] = ST_OPEN;
          open_seq[n] = seq++;
          better = 1'b1;
        end else begin
          better = t < g_cost[n];
        end
        if (better) begin
          par_dir[n] = k + 1;
          g_cost[n] = t;
          f_est[n] = t + dist_h(nx, ny, gx, gy);
        end
      end
    end
    goal_reached = 1'b1;
    c = goal;
    for (int guard = 0; guard < CELLS; guard++) begin
      d = par_dir[c];
      if (d == 0 || c == start) break;
      if (route_len < PATH_DEPTH) route[route_len++] = c;
      cx = c % COLS - dir_dx[d-1];
      cy = c / COLS - dir_dy[d-1];
      if (cx < 0 || cy < 0 || cx >= COLS || cy >= ROWS) break;
      c = cy * COLS + cx;
    end
  endfunction

  function automatic path_reply_t apply_item();
    path_reply_t r;
    r = '0;
    case (mode_t'(in_mode))
      MODE_WRITE:  walk_bits[in_cell_y * COLS + in_cell_x] = in_walkable;
      MODE_SEARCH: search_route(in_cell_x, in_cell_y, in_goal_x, in_goal_y);
      MODE_READ: begin
        if (in_path_index < route_len) begin
          r.px = XY_W'(route[in_path_index] % COLS);
          r.py = XY_W'(route[in_path_index] / COLS);
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.found = goal_reached;
    r.length = LEN_W'(route_len);
    return r;
  endfunction

  always @(posedge clk) begin
    path_reply_t exp_r, got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_found, out_path_length, out_path_x, out_path_y, out_index_ok};
      if (reply_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: unexpected transaction found=%0d len=%0d x=%0d y=%0d ok=%0d",
                   $realtime, got.found, got.length, got.px, got.py, got.ok);
      end else begin
        exp_r = reply_q.pop_front();
        if (got !== exp_r) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"%0t: mismatch exp found=%0d len=%0d x=%0d y=%0d ok=%0d,",
                      " got found=%0d len=%0d x=%0d y=%0d ok=%0d"},
                     $realtime, exp_r.found, exp_r.length, exp_r.px, exp_r.py, exp_r.ok,
                     got.found, got.length, got.px, got.py, got.ok);
        end
      end
    end
    if (rst_n && in_valid && !in_stall) reply_q = {reply_q, apply_item()};
    outstanding = reply_q.size();
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench import gaps_pkg::*;;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [1:0]       in_mode;
  logic [XY_W-1:0]  in_cell_x;
  logic [XY_W-1:0]  in_cell_y;
  logic             in_walkable;
  logic [XY_W-1:0]  in_goal_x;
  logic [XY_W-1:0]  in_goal_y;
  logic [LEN_W-1:0] in_path_index;
  logic             out_valid;
  logic             out_stall;
  logic             out_found;
  logic [LEN_W-1:0] out_path_length;
  logic [XY_W-1:0]  out_path_x;
  logic [XY_W-1:0]  out_path_y;
  logic             out_index_ok;
  int               fail_count;
  int               outstanding;
  int               n_sent;
  bit               open_map[1024];

  grid_astar_path_search DUT (.*);

  path_search_checker u_checker (.*);

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit calm_window();
    return n_sent >= 60 && n_sent < 100;
  endfunction

  task automatic send_item(mode_t m, int cx, int cy, bit w, int gx, int gy, int idx);
    while (!calm_window() && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_cell_x <= XY_W'(cx);
    in_cell_y <= XY_W'(cy);
    in_walkable <= w;
    in_goal_x <= XY_W'(gx);
    in_goal_y <= XY_W'(gy);
    in_path_index <= LEN_W'(idx);
    do @(posedge clk); while (in_stall);
    if (m == MODE_WRITE) open_map[cy * 32 + cx] = w;
    n_sent++;
  endtask

  // Receiver: random stalls, one long hold-off to back up the block
  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (!held && n_sent >= 30) begin
        hold = 400;
        held = 1;
        out_stall <= 1'b1;
      end else if (calm_window()) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 11);
      end
    end
  end

  initial begin
    #1_000_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int sx, sy, gx, gy, pick, idx;
    n_sent = 0;
    foreach (open_map[i]) open_map[i] = 1'b1;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_mode <= MODE_WRITE;
    in_cell_x <= '0;
    in_cell_y <= '0;
    in_walkable <= 1'b0;
    in_goal_x <= '0;
    in_goal_y <= '0;
    in_path_index <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_item(MODE_READ, 0, 0, 0, 0, 0, 0);
    send_item(MODE_NONE, 31, 31, 1, 31, 31, 1023);
    send_item(MODE_SEARCH, 31, 31, 0, 31, 31, 0);      // start on goal
    send_item(MODE_READ, 0, 0, 0, 0, 0, 0);
    send_item(MODE_SEARCH, 0, 0, 1, 2, 1, 0);
    send_item(MODE_READ, 0, 0, 0, 0, 0, 0);
    send_item(MODE_READ, 0, 0, 0, 0, 0, 1);
    send_item(MODE_READ, 0, 0, 0, 0, 0, 2);
    send_item(MODE_READ, 0, 0, 0, 0, 0, 1023);
    // wall in the corner cell
    send_item(MODE_WRITE, 1, 0, 0, 0, 0, 0);
    send_item(MODE_WRITE, 0, 1, 0, 0, 0, 0);
    send_item(MODE_WRITE, 1, 1, 0, 0, 0, 0);
    send_item(MODE_SEARCH, 0, 0, 0, 1, 1, 0);          // goal blocked
    send_item(MODE_SEARCH, 0, 0, 0, 5, 5, 0);          // no way out
    send_item(MODE_READ, 0, 0, 0, 0, 0, 0);
    send_item(MODE_WRITE, 0, 0, 0, 0, 0, 0);
    send_item(MODE_WRITE, 1, 0, 1, 0, 0, 0);
    send_item(MODE_SEARCH, 0, 0, 1, 2, 0, 0);          // start is a wall
    send_item(MODE_READ, 0, 0, 0, 0, 0, 1);
    send_item(MODE_WRITE, 0, 0, 1, 0, 0, 0);
    send_item(MODE_WRITE, 0, 1, 1, 0, 0, 0);
    send_item(MODE_WRITE, 1, 1, 1, 0, 0, 0);
    send_item(MODE_SEARCH, 30, 29, 0, 31, 31, 0);
    send_item(MODE_READ, 0, 0, 0, 0, 0, 512);

    repeat (116) begin
      pick = $urandom_range(0, 99);
      sx = $urandom_range(0, 31);
      sy = $urandom_range(0, 31);
      gx = sx + $urandom_range(0, 4) - 2;
      gy = sy + $urandom_range(0, 4) - 2;
      gx = gx < 0 ? 0 : (gx > 31 ? 31 : gx);
      gy = gy < 0 ? 0 : (gy > 31 ? 31 : gy);
      idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 4);
      if (pick < 30)
        send_item(MODE_WRITE, sx, sy, $urandom_range(0, 3) != 0, $urandom_range(0, 31),
                  $urandom_range(0, 31), $urandom_range(0, 1023));
      // keep searches local: a blocked goal would sweep the whole grid
      else if (pick < 55 && open_map[gy * 32 + gx])
        send_item(MODE_SEARCH, sx, sy, $urandom_range(0, 1), gx, gy, $urandom_range(0, 1023));
      else if (pick < 90)
        send_item(MODE_READ, sx, sy, $urandom_range(0, 1), gx, gy, idx);
      else
        send_item(MODE_NONE, sx, sy, $urandom_range(0, 1), gx, gy, idx);
    end
    in_valid <= 1'b0;

    // let the checker record the last transaction before polling its queue
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
